/* design/prp_pkg.sv */
// Shared types and constants for the page replacement policy engine.
package prp_pkg;

	localparam logic [1:0] MODE_FIFO = 2'd0;
	localparam logic [1:0] MODE_LRU = 2'd1;
	localparam logic [1:0] MODE_LFU = 2'd2;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_FRAMES = 2'd1;

	localparam int LRU_START = 10;

	typedef enum logic [2:0] {
		RANK_HOLD = 3'd0,
		RANK_SEED = 3'd1,
		RANK_AGE = 3'd2,
		RANK_INC = 3'd3,
		RANK_LOAD1 = 3'd4
	} rank_op_t;

	typedef struct packed {
		logic write;
		logic clear;
		rank_op_t rank_op;
		logic seed_lru;
	} cmd_t;

endpackage

/* design/page_replacement_policy_engine.sv */
// Top level of the page replacement policy engine: control, chain of frame cells, result register.
// The block takes one page reference per item on the input channel and returns one
// result item per reference on the output channel: hit flag, frame index, evicted page
// and the running fault count of the current string.
// Configuration writes (policy at index 0, frame count at index 1) arrive on their own
// channel, which is always ready, and must only be issued while no item is in flight.
// Writing the policy reseeds every rank counter for the new policy.
// An accepted item is held while a search token walks the frame cells, one cell per
// cycle, gathering the hit frame and the victim candidate. The decision state then picks the
// frame, updates the cells and loads the result register.
// An item therefore passes through the idle, scan and decision states before the next accept;
// the scan covers only the active frames, not the whole chain of cells.
// The result register lets the next item be accepted while a result waits; if the
// receiver stalls, the following item waits in its decision cycle until the register frees.
// Reset empties all frames, clears the pointer and fault count and selects FIFO with
// all frames active. After an item marked last in string, the same clearing happens.
module page_replacement_policy_engine #(
	parameter int FRAMES = 8,
	parameter int PAGE_BITS = 16,
	parameter int RANK_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [3:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [PAGE_BITS-1:0] page_number,
	input logic last_in_string,
	output logic out_valid,
	input logic out_ready,
	output logic hit,
	output logic [2:0] frame_index,
	output logic evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [31:0] fault_total,
	output logic string_done
);
	import prp_pkg::*;

	localparam int NW = $clog2(FRAMES + 1);
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int XW = (NW > 4) ? NW : 4;
	localparam int KW = RANK_BITS + 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

	state_t state_q;
	logic [NW-1:0] cnt_q;
	logic [PAGE_BITS-1:0] page_q;
	logic done_q;
	logic [1:0] policy_q;
	logic [3:0] frames_q;
	logic [IW-1:0] ptr_q;
	logic [NW-1:0] last_q;
	logic [31:0] fault_q;

	logic out_valid_q;
	logic hit_q;
	logic [2:0] fidx_q;
	logic evv_q;
	logic [PAGE_BITS-1:0] evp_q;
	logic [31:0] ftot_q;
	logic sdone_q;

	logic match_tok [FRAMES+1];
	logic [IW-1:0] midx_tok [FRAMES+1];
	logic vset_tok [FRAMES+1];
	logic [IW-1:0] vidx_tok [FRAMES+1];
	logic [KW-1:0] vkey_tok [FRAMES+1];
	logic [PAGE_BITS-1:0] cell_page [FRAMES];
	logic cell_valid [FRAMES];

	logic [XW-1:0] fx;
	logic [NW-1:0] n_act;
	logic fire;
	logic cfg_fire;
	logic tok_match;
	logic [IW-1:0] idx;
	logic [IW-1:0] ptr_base;
	logic [NW-1:0] ptr_inc;
	logic [IW-1:0] ptr_next;
	logic ev_valid;
	logic [PAGE_BITS-1:0] ev_page;
	logic [31:0] fault_next;
	cmd_t cmd;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid;
	assign in_ready = (state_q == S_IDLE);
	assign fire = (state_q == S_DECIDE) && (!out_valid_q || out_ready);

	always_comb begin
		fx = XW'(frames_q);
		if (fx == '0) begin
			n_act = NW'(1);
		end else if (fx > XW'(FRAMES)) begin
			n_act = NW'(FRAMES);
		end else begin
			n_act = NW'(fx);
		end
	end

	assign match_tok[0] = 1'b0;
	assign midx_tok[0] = '0;
	assign vset_tok[0] = 1'b0;
	assign vidx_tok[0] = '0;
	assign vkey_tok[0] = '0;

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		prp_cell #(
			.FRAMES(FRAMES),
			.PAGE_BITS(PAGE_BITS),
			.RANK_BITS(RANK_BITS),
			.IDX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.mode(policy_q),
			.last_touched(last_q),
			.n_act(n_act),
			.item_page(page_q),
			.cmd(cmd),
			.sel_idx(idx),
			.up_match(match_tok[g]),
			.up_match_idx(midx_tok[g]),
			.up_vic_set(vset_tok[g]),
			.up_vic_idx(vidx_tok[g]),
			.up_vic_key(vkey_tok[g]),
			.down_match(match_tok[g+1]),
			.down_match_idx(midx_tok[g+1]),
			.down_vic_set(vset_tok[g+1]),
			.down_vic_idx(vidx_tok[g+1]),
			.down_vic_key(vkey_tok[g+1]),
			.cell_page(cell_page[g]),
			.cell_valid(cell_valid[g])
		);
	end

	always_comb begin
		tok_match = match_tok[n_act];
		ptr_base = (NW'(ptr_q) >= n_act) ? '0 : ptr_q;
		ptr_inc = NW'(ptr_base) + NW'(1);
		ptr_next = (ptr_inc < n_act) ? ptr_inc[IW-1:0] : '0;
		if (tok_match) begin
			idx = midx_tok[n_act];
		end else if (policy_q == MODE_FIFO) begin
			idx = ptr_base;
		end else if (policy_q == MODE_LRU) begin
			idx = vidx_tok[n_act];
		end else begin
			idx = vset_tok[n_act] ? vidx_tok[n_act] : '0;
		end
		ev_valid = !tok_match && cell_valid[idx];
		ev_page = ev_valid ? cell_page[idx] : '0;
		if (tok_match || (fault_q == '1)) begin
			fault_next = fault_q;
		end else begin
			fault_next = fault_q + 32'd1;
		end
	end

	always_comb begin
		cmd = '{write: 1'b0, clear: 1'b0, rank_op: RANK_HOLD, seed_lru: 1'b0};
		if (fire) begin
			if (done_q) begin
				cmd.clear = 1'b1;
				cmd.rank_op = RANK_SEED;
				cmd.seed_lru = (policy_q == MODE_LRU);
			end else begin
				cmd.write = !tok_match;
				if (policy_q == MODE_LRU) begin
					cmd.rank_op = RANK_AGE;
				end else if (policy_q == MODE_FIFO) begin
					cmd.rank_op = RANK_HOLD;
				end else begin
					cmd.rank_op = tok_match ? RANK_INC : RANK_LOAD1;
				end
			end
		end else if (cfg_fire && (cfg_index == REG_POLICY)) begin
			cmd.rank_op = RANK_SEED;
			cmd.seed_lru = (cfg_data[1:0] == MODE_LRU);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_q <= page_number;
			done_q <= last_in_string;
		end
		if (fire) begin
			hit_q <= tok_match;
			fidx_q <= 3'(idx);
			evv_q <= ev_valid;
			evp_q <= ev_page;
			ftot_q <= fault_next;
			sdone_q <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			policy_q <= MODE_FIFO;
			frames_q <= 4'd8;
			ptr_q <= '0;
			last_q <= NW'(FRAMES);
			fault_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				if (cfg_index == REG_POLICY) begin
					policy_q <= cfg_data[1:0];
				end else if (cfg_index == REG_FRAMES) begin
					frames_q <= cfg_data;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q <= n_act - NW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == '0) begin
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q - NW'(1);
					end
				end
				S_DECIDE: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
				if (done_q) begin
					ptr_q <= '0;
					last_q <= NW'(FRAMES);
					fault_q <= '0;
				end else begin
					if (!tok_match && (policy_q == MODE_FIFO)) begin
						ptr_q <= ptr_next;
					end
					last_q <= NW'(idx);
					fault_q <= fault_next;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign frame_index = fidx_q;
	assign evicted_valid = evv_q;
	assign evicted_page = evp_q;
	assign fault_total = ftot_q;
	assign string_done = sdone_q;

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && evv_q))
		else $error("result shows both a hit and an eviction");

	a_string_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && done_q) |=> (fault_q == '0) && (last_q == NW'(FRAMES)))
		else $error("string state not cleared after the last item");

	a_hit_keeps_faults: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && tok_match && !done_q) |=> $stable(fault_q))
		else $error("fault count changed on a hit");

	a_last_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		last_q <= NW'(FRAMES))
		else $error("last touched frame out of range");

endmodule

/* design/prp_cell.sv */
// One frame cell: page, valid bit and rank counter, plus one stage of the hit and victim search chain.
module prp_cell #(
	parameter int FRAMES = 8,
	parameter int PAGE_BITS = 16,
	parameter int RANK_BITS = 16,
	parameter int IDX = 0,
	localparam int NW = $clog2(FRAMES + 1),
	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int KW = RANK_BITS + 1
) (
	input logic clk,
	input logic arst_n,
	input logic [1:0] mode,
	input logic [NW-1:0] last_touched,
	input logic [NW-1:0] n_act,
	input logic [PAGE_BITS-1:0] item_page,
	input prp_pkg::cmd_t cmd,
	input logic [IW-1:0] sel_idx,
	input logic up_match,
	input logic [IW-1:0] up_match_idx,
	input logic up_vic_set,
	input logic [IW-1:0] up_vic_idx,
	input logic [KW-1:0] up_vic_key,
	output logic down_match,
	output logic [IW-1:0] down_match_idx,
	output logic down_vic_set,
	output logic [IW-1:0] down_vic_idx,
	output logic [KW-1:0] down_vic_key,
	output logic [PAGE_BITS-1:0] cell_page,
	output logic cell_valid
);
	import prp_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);
	localparam logic [NW-1:0] MY_POS = NW'(IDX);
	localparam logic [RANK_BITS-1:0] RANK_MAX = '1;

	logic [PAGE_BITS-1:0] page_q;
	logic valid_q;
	logic [RANK_BITS-1:0] rank_q;
	logic match_q;
	logic [IW-1:0] match_idx_q;
	logic vic_set_q;
	logic [IW-1:0] vic_idx_q;
	logic [KW-1:0] vic_key_q;

	logic here;
	logic [KW-1:0] key;
	logic take;
	logic is_sel;
	logic active;
	logic [RANK_BITS-1:0] rank_inc;

	always_comb begin
		here = valid_q && (page_q == item_page);
		if (mode == MODE_LRU) begin
			key = {1'b0, rank_q};
			take = !up_vic_set || (key > up_vic_key);
		end else begin
			key = valid_q ? (KW'(rank_q) + KW'(1)) : '0;
			take = (MY_POS != last_touched) && (!up_vic_set || (key < up_vic_key));
		end
		is_sel = (sel_idx == MY_IDX);
		active = (MY_POS < n_act);
		rank_inc = (rank_q == RANK_MAX) ? rank_q : rank_q + RANK_BITS'(1);
	end

	always_ff @(posedge clk) begin
		match_q <= up_match || here;
		match_idx_q <= up_match ? up_match_idx : MY_IDX;
		vic_set_q <= up_vic_set || take;
		vic_idx_q <= take ? MY_IDX : up_vic_idx;
		vic_key_q <= take ? key : up_vic_key;
		if (cmd.write && is_sel) begin
			page_q <= item_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q <= '0;
		end else begin
			if (cmd.clear) begin
				valid_q <= 1'b0;
			end else if (cmd.write && is_sel) begin
				valid_q <= 1'b1;
			end
			unique case (cmd.rank_op)
				RANK_HOLD: begin
				end
				RANK_SEED: begin
					rank_q <= cmd.seed_lru ? RANK_BITS'(LRU_START) : '0;
				end
				RANK_AGE: begin
					if (active) begin
						rank_q <= is_sel ? '0 : rank_inc;
					end
				end
				RANK_INC: begin
					if (is_sel) begin
						rank_q <= rank_inc;
					end
				end
				RANK_LOAD1: begin
					if (is_sel) begin
						rank_q <= RANK_BITS'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign down_match = match_q;
	assign down_match_idx = match_idx_q;
	assign down_vic_set = vic_set_q;
	assign down_vic_idx = vic_idx_q;
	assign down_vic_key = vic_key_q;
	assign cell_page = page_q;
	assign cell_valid = valid_q;

endmodule

/* verif/page_replacement_policy_engine_tb.sv */
// Self-checking testbench for the page replacement policy engine, with a built-in policy predictor.
`timescale 1ns / 100ps

module page_replacement_policy_engine_tb;
	import prp_pkg::*;

	localparam int NUM_FRAMES = 8;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd2;
	localparam logic [15:0] RANK_MAX = 16'hFFFF;
	localparam int RANDOM_REFS = 830;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [15:0] page;
		logic last;
	} page_ref_t;

	typedef struct packed {
		logic hit;
		logic [2:0] frame;
		logic ev_valid;
		logic [15:0] ev_page;
		logic [31:0] faults;
		logic done;
	} page_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] page_number = '0;
	logic last_in_string = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic [2:0] frame_index;
	logic evicted_valid;
	logic [15:0] evicted_page;
	logic [31:0] fault_total;
	logic string_done;

	page_replacement_policy_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.page_number(page_number),
		.last_in_string(last_in_string),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.frame_index(frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page(evicted_page),
		.fault_total(fault_total),
		.string_done(string_done)
	);

	// Predictor state.
	logic [1:0] policy;
	logic [3:0] frame_limit;
	logic [15:0] fr_page [NUM_FRAMES];
	logic fr_valid [NUM_FRAMES];
	logic [15:0] rank [NUM_FRAMES];
	int fifo_ptr;
	int last_frame;
	logic [31:0] faults;

	page_ref_t pending_refs [$];
	page_result_t expected_results [$];
	page_ref_t next_ref;
	logic offer_busy;

	int send_idle = 31;
	int recv_idle = 53;
	int refs_queued = 0;
	int refs_accepted = 0;
	int results_checked = 0;
	int mismatches = 0;
	int hits_seen = 0;
	int strings_closed = 0;
	int reg_writes = 0;
	int hold_left;
	logic hold_done;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void reseed_ranks();
		for (int i = 0; i < NUM_FRAMES; i++)
			rank[i] = (policy == MODE_LRU) ? 16'(LRU_START) : 16'd0;
	endfunction

	function automatic void clear_string();
		for (int i = 0; i < NUM_FRAMES; i++) begin
			fr_page[i] = '0;
			fr_valid[i] = 1'b0;
		end
		fifo_ptr = 0;
		last_frame = NUM_FRAMES;
		faults = '0;
		reseed_ranks();
	endfunction

	function automatic void age_ranks(input int n, input int used);
		for (int i = 0; i < n; i++) begin
			if (i == used)
				rank[i] = '0;
			else if (rank[i] != RANK_MAX)
				rank[i] = rank[i] + 16'd1;
		end
	endfunction

	// Empty frames rank below every occupied frame.
	function automatic logic [16:0] use_key(input int i);
		return fr_valid[i] ? ({1'b0, rank[i]} + 17'd1) : 17'd0;
	endfunction

	function automatic void predict_reference(input logic [15:0] page, input logic last);
		int n;
		int idx;
		page_result_t r;
		n = (frame_limit == 0) ? 1 : (frame_limit > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit);
		idx = n;
		r = '0;
		for (int i = 0; i < n; i++)
			if (idx == n && fr_valid[i] && fr_page[i] == page)
				idx = i;
		if (idx < n) begin
			r.hit = 1'b1;
			if (policy == MODE_LRU)
				age_ranks(n, idx);
			else if (policy != MODE_FIFO && rank[idx] != RANK_MAX)
				rank[idx] = rank[idx] + 16'd1;
		end else begin
			if (policy == MODE_FIFO) begin
				if (fifo_ptr >= n)
					fifo_ptr = 0;
				idx = fifo_ptr;
				fifo_ptr = (fifo_ptr + 1 < n) ? fifo_ptr + 1 : 0;
			end else if (policy == MODE_LRU) begin
				idx = 0;
				for (int i = 1; i < n; i++)
					if (rank[i] > rank[idx])
						idx = i;
			end else begin
				idx = n;
				for (int i = 0; i < n; i++)
					if (i != last_frame && (idx == n || use_key(i) < use_key(idx)))
						idx = i;
				if (idx == n)
					idx = 0;
			end
			if (fr_valid[idx]) begin
				r.ev_valid = 1'b1;
				r.ev_page = fr_page[idx];
			end
			fr_page[idx] = page;
			fr_valid[idx] = 1'b1;
			if (policy == MODE_LRU)
				age_ranks(n, idx);
			else if (policy != MODE_FIFO)
				rank[idx] = 16'd1;
			if (faults != '1)
				faults = faults + 32'd1;
		end
		last_frame = idx;
		r.frame = idx[2:0];
		r.faults = faults;
		r.done = last;
		expected_results.push_back(r);
		if (last) begin
			clear_string();
			strings_closed++;
		end
	endfunction

	function automatic string describe(input page_result_t r);
		return $sformatf("hit=%0d frame=%0d evicted=%0d page=%h faults=%0d done=%0d",
			r.hit, r.frame, r.ev_valid, r.ev_page, r.faults, r.done);
	endfunction

	task automatic check_result();
		page_result_t got;
		page_result_t want;
		got.hit = hit;
		got.frame = frame_index;
		got.ev_valid = evicted_valid;
		got.ev_page = evicted_page;
		got.faults = fault_total;
		got.done = string_done;
		results_checked++;
		if (got.hit)
			hits_seen++;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result item with no reference pending: %s", $time, describe(got));
		end else begin
			want = expected_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %0d mismatch\n  expected %s\n  actual   %s",
						$time, results_checked, describe(want), describe(got));
			end
		end
	endtask

	task automatic queue_ref(input logic [15:0] page, input logic last);
		page_ref_t r;
		r.page = page;
		r.last = last;
		pending_refs.push_back(r);
		refs_queued++;
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [3:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (index == REG_POLICY) begin
			policy = data[1:0];
			reseed_ranks();
		end else if (index == REG_FRAMES) begin
			frame_limit = data;
		end
		reg_writes++;
	endtask

	task automatic drain();
		while (refs_accepted != refs_queued || results_checked < refs_accepted)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			page_number <= '0;
			last_in_string <= 1'b0;
		end else begin
			offer_busy = in_valid;
			if (in_valid && in_ready) begin
				predict_reference(page_number, last_in_string);
				refs_accepted++;
				offer_busy = 1'b0;
			end
			if (!offer_busy) begin
				if (pending_refs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					next_ref = pending_refs.pop_front();
					in_valid <= 1'b1;
					page_number <= next_ref.page;
					last_in_string <= next_ref.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver and result checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (!hold_done && results_checked >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int budget;
		int string_left;
		int random_refs;
		int regime;
		logic [15:0] working_set [$];
		logic [15:0] pg;
		logic [3:0] frames_data;

		policy = MODE_FIFO;
		frame_limit = 4'd8;
		clear_string();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// FIFO over all frames, then shrink the frame count so the pointer wraps.
		queue_ref(16'h0000, 1'b0);
		queue_ref(16'h0000, 1'b0);
		queue_ref(16'hFFFF, 1'b0);
		queue_ref(16'h0001, 1'b0);
		queue_ref(16'h0002, 1'b0);
		queue_ref(16'h0003, 1'b0);
		drain();
		write_reg(REG_FRAMES, 4'd3);
		queue_ref(16'h0007, 1'b0);
		queue_ref(16'h0002, 1'b0);
		queue_ref(16'h8000, 1'b1);
		drain();

		// LFU with a frame count of zero, which acts as a single frame.
		write_reg(REG_POLICY, {2'b00, MODE_LFU});
		write_reg(REG_FRAMES, 4'd0);
		queue_ref(16'hA5A5, 1'b0);
		queue_ref(16'h5A5A, 1'b0);
		queue_ref(16'h5A5A, 1'b1);
		drain();

		write_reg(REG_POLICY, {2'b00, MODE_LRU});
		write_reg(REG_FRAMES, 4'd2);
		queue_ref(16'h0010, 1'b0);
		queue_ref(16'h0020, 1'b0);
		queue_ref(16'h0010, 1'b0);
		queue_ref(16'h0030, 1'b0);
		queue_ref(16'h0020, 1'b1);
		drain();

		// Unused policy code and an oversized frame count.
		write_reg(REG_SPARE, 4'hF);
		write_reg(REG_POLICY, {2'b11, MODE_SPARE});
		write_reg(REG_FRAMES, 4'hF);
		queue_ref(16'h0100, 1'b0);
		queue_ref(16'h0100, 1'b0);
		queue_ref(16'h0200, 1'b0);
		queue_ref(16'h0300, 1'b0);
		queue_ref(16'h0100, 1'b1);
		drain();

		// Random strings over small working sets; strings may run across policy changes.
		string_left = 0;
		random_refs = 0;
		while (random_refs < RANDOM_REFS) begin
			regime = random_refs * 3 / RANDOM_REFS;
			send_idle = (regime == 0) ? 31 : (regime == 1) ? 53 : 0;
			recv_idle = (regime == 0) ? 53 : (regime == 1) ? 31 : 0;
			case ($urandom_range(0, 4))
				0: frames_data = 4'd1;
				1: frames_data = 4'd8;
				2: frames_data = 4'($urandom_range(9, 15));
				default: frames_data = 4'($urandom_range(0, 8));
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(REG_POLICY, 4'($urandom_range(0, 15)));
				write_reg(REG_FRAMES, frames_data);
			end else begin
				write_reg(REG_FRAMES, frames_data);
				write_reg(REG_POLICY, 4'($urandom_range(0, 15)));
			end
			budget = $urandom_range(30, 70);
			for (int k = 0; k < budget && random_refs < RANDOM_REFS; k++) begin
				if (string_left == 0) begin
					string_left = $urandom_range(1, 40);
					working_set.delete();
					repeat ($urandom_range(1, 12))
						working_set.push_back(16'($urandom_range(0, 65535)));
				end
				if ($urandom_range(0, 99) < 88)
					pg = working_set[$urandom_range(0, working_set.size() - 1)];
				else
					pg = 16'($urandom_range(0, 65535));
				queue_ref(pg, string_left == 1);
				string_left--;
				random_refs++;
			end
			drain();
		end

		$display("Checked %0d results from %0d page references: %0d hits, %0d strings closed.",
			results_checked, refs_accepted, hits_seen, strings_closed);
		$display("%0d register writes; receiver held off %0d cycles once; %0d mismatches.",
			reg_writes, HOLD_CYCLES, mismatches);
		if (expected_results.size() != 0)
			$display("%0d expected results never arrived.", expected_results.size());
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
design/prp_pkg.sv
design/prp_cell.sv
design/page_replacement_policy_engine.sv
verif/page_replacement_policy_engine_tb.sv
